// ----- rtl/core/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared constants and types of the tilted paddle pair hit test pipeline.
// ----------------------------------------------------------------------------
package tpp_pkg;

	localparam int FRAC = 16;                // fraction bits of all fixed point values
	localparam int SINE_DEPTH = 1024;        // quarter wave table steps
	localparam int SINE_W = 17;              // table entry width, 0 .. 1.0
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int NUM_W = 27;               // signed numerator width
	localparam int DEN_W = 25;               // signed denominator width
	localparam int QUO_W = 32;               // quotient bits, one per divider stage
	localparam int DIV_STEPS = QUO_W;

	localparam int FRONT_STAGES = 5;
	localparam int PLANE_STAGES = 6;

	// Register indexes of the write port
	localparam logic [2:0] CFG_SIN_TILT     = 3'd0;
	localparam logic [2:0] CFG_COS_TILT     = 3'd1;
	localparam logic [2:0] CFG_TAN_TILT     = 3'd2;
	localparam logic [2:0] CFG_SEC_TILT     = 3'd3;
	localparam logic [2:0] CFG_PLANE_GAP    = 3'd4;
	localparam logic [2:0] CFG_HALF_LENGTH  = 3'd5;
	localparam logic [2:0] CFG_HALF_BREADTH = 3'd6;
	localparam logic [2:0] CFG_SPARE        = 3'd7;

	// Track data that travels alongside the divider
	typedef struct packed {
		logic signed [19:0] x1;
		logic signed [19:0] y1;
		logic signed [17:0] st;
		logic signed [17:0] sp;
		logic signed [17:0] cp;
		logic               degen;
	} trk_t;

endpackage

// ----- rtl/core/tpp_if.sv -----
// ----------------------------------------------------------------------------
// tpp_if
// Valid/ready channels for track beats and hit result beats.
// ----------------------------------------------------------------------------
interface tpp_track_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] entry_x;
	logic signed [19:0] entry_y;
	logic        [14:0] zenith;
	logic        [15:0] azimuth;

	modport source (output valid, entry_x, entry_y, zenith, azimuth, input ready);
	modport sink (input valid, entry_x, entry_y, zenith, azimuth, output ready);
endinterface

interface tpp_result_if;
	logic               valid;
	logic               ready;
	logic               hit_first;
	logic               hit_second;
	logic               both_hit;
	logic signed [15:0] first_x;
	logic signed [15:0] first_y;
	logic signed [15:0] second_x;
	logic signed [15:0] second_y;
	logic               degenerate;

	modport source (output valid, hit_first, hit_second, both_hit, first_x, first_y,
		second_x, second_y, degenerate, input ready);
	modport sink (input valid, hit_first, hit_second, both_hit, first_x, first_y,
		second_x, second_y, degenerate, output ready);
endinterface

// ----- rtl/core/tilted_paddle_pair_hit_test_unit.sv -----
// ----------------------------------------------------------------------------
// tilted_paddle_pair_hit_test_unit
// Intersects one straight track with two tilted rectangular planes.
//
//   channel   direction  beat
//   track     in         entry_x, entry_y, zenith, azimuth
//   result    out        hit flags, local x/y on both planes, degenerate
//   wr_*      in         register write, index 0..6, no read-back
//
// One track per cycle while the pipeline is not held; a track beat passes
// 5 front stages (sine ROM read, trig products, denominator), 32 divider
// stages at one quotient bit each, 6 plane stages and the output register.
// Reset clears the valid bits, output valid included, and loads the register
// defaults.
// The pipeline holds only while its last stage and the output register are
// both full and the result is not taken.
// ----------------------------------------------------------------------------
module tilted_paddle_pair_hit_test_unit #(
	parameter int SINE_TABLE_DEPTH = tpp_pkg::SINE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [2:0]   wr_index,
	input  logic [19:0]  wr_data,
	tpp_track_if.sink    track,
	tpp_result_if.source result
);
	import tpp_pkg::*;

	localparam int NS = FRONT_STAGES + DIV_STEPS + PLANE_STAGES;

	logic signed [17:0] sin_tilt_q;
	logic        [16:0] cos_tilt_q;
	logic signed [19:0] tan_tilt_q;
	logic        [18:0] sec_tilt_q;
	logic        [17:0] plane_gap_q;
	logic        [14:0] half_length_q;
	logic        [14:0] half_breadth_q;
	logic        [15:0] hbc_q;
	logic signed [19:0] off_q;
	logic        [20:0] gsc_q;

	logic          en;
	logic          res_take;
	logic [NS:1]   vld_s;

	logic signed [17:0] st_w, ct_w, sp_w, cp_w;
	logic signed [19:0] x1_s1, y1_s1;
	logic signed [39:0] ytn_s1;
	logic signed [26:0] num1_w;

	logic signed [17:0] st_s2, ct_s2, sp_s2, cp_s2;
	logic signed [19:0] x1_s2, y1_s2;
	logic signed [37:0] tsn_s2;
	logic signed [26:0] num1_s2, num2_s2;

	logic signed [17:0] st_s3, ct_s3, sp_s3, cp_s3;
	logic signed [19:0] x1_s3, y1_s3;
	logic signed [39:0] a_s3;
	logic signed [26:0] num1_s3, num2_s3;

	logic signed [17:0] st_s4, sp_s4, cp_s4;
	logic signed [19:0] x1_s4, y1_s4;
	logic signed [24:0] den_s4;
	logic signed [26:0] num1_s4, num2_s4;

	logic [DEN_W-1:0] dmag_s5;
	logic [NUM_W-1:0] nmag1_s5, nmag2_s5;
	logic             neg1_s5, neg2_s5;
	trk_t             trk_s5;
	trk_t             trk_d [0:DIV_STEPS-1];

	logic [QUO_W-1:0] quo1, quo2;
	logic             ovf1, ovf2, qneg1, qneg2;
	logic             hit1, hit2, degen1, degen2;
	logic signed [15:0] lx1, ly1, lx2, ly2;

	logic               out_v_q;
	logic               hit1_q, hit2_q, degen_q;
	logic signed [15:0] lx1_q, ly1_q, lx2_q, ly2_q;

	// Registers and values derived from them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_tilt_q <= '0;
			cos_tilt_q <= 17'd65536;
			tan_tilt_q <= '0;
			sec_tilt_q <= 19'd65536;
			plane_gap_q <= 18'd19661;
			half_length_q <= 15'd26214;
			half_breadth_q <= 15'd9830;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SIN_TILT:     sin_tilt_q <= wr_data[17:0];
				CFG_COS_TILT:     cos_tilt_q <= wr_data[16:0];
				CFG_TAN_TILT:     tan_tilt_q <= wr_data;
				CFG_SEC_TILT:     sec_tilt_q <= wr_data[18:0];
				CFG_PLANE_GAP:    plane_gap_q <= wr_data[17:0];
				CFG_HALF_LENGTH:  half_length_q <= wr_data[14:0];
				CFG_HALF_BREADTH: half_breadth_q <= wr_data[14:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		hbc_q <= 16'((32'(half_breadth_q) * 32'(cos_tilt_q)) >> FRAC);
		off_q <= 20'((37'($signed({1'b0, plane_gap_q})) * 37'(sin_tilt_q)) >>> FRAC);
		gsc_q <= 21'((37'(plane_gap_q) * 37'(sec_tilt_q)) >> FRAC);
	end

	// Flow control: the output register parts the pipeline from the sink
	assign res_take = !out_v_q || result.ready;
	assign en = !vld_s[NS] || res_take;
	assign track.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[NS-1:1], track.valid};
	end

	tpp_sine #(.Depth(SINE_TABLE_DEPTH)) u_sine_zen (
		.clk(clk), .en(en), .ang({1'b0, track.zenith}), .sin_val(st_w), .cos_val(ct_w)
	);

	tpp_sine #(.Depth(SINE_TABLE_DEPTH)) u_sine_azi (
		.clk(clk), .en(en), .ang(track.azimuth), .sin_val(sp_w), .cos_val(cp_w)
	);

	assign num1_w = $signed(27'(half_breadth_q)) - 27'(ytn_s1 >>> FRAC);

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= track.entry_x;
			y1_s1 <= track.entry_y;
			ytn_s1 <= 40'(track.entry_y) * 40'(tan_tilt_q);

			st_s2 <= st_w;
			ct_s2 <= ct_w;
			sp_s2 <= sp_w;
			cp_s2 <= cp_w;
			x1_s2 <= x1_s1;
			y1_s2 <= y1_s1;
			tsn_s2 <= 38'(tan_tilt_q) * 38'(st_w);
			num1_s2 <= num1_w;
			num2_s2 <= num1_w + $signed(27'(gsc_q));

			st_s3 <= st_s2;
			ct_s3 <= ct_s2;
			sp_s3 <= sp_s2;
			cp_s3 <= cp_s2;
			x1_s3 <= x1_s2;
			y1_s3 <= y1_s2;
			a_s3 <= 40'(22'(tsn_s2 >>> FRAC)) * 40'(sp_s2);
			num1_s3 <= num1_s2;
			num2_s3 <= num2_s2;

			st_s4 <= st_s3;
			sp_s4 <= sp_s3;
			cp_s4 <= cp_s3;
			x1_s4 <= x1_s3;
			y1_s4 <= y1_s3;
			den_s4 <= 25'(ct_s3) + 25'(a_s3 >>> FRAC);
			num1_s4 <= num1_s3;
			num2_s4 <= num2_s3;

			dmag_s5 <= den_s4[DEN_W-1] ? DEN_W'(-den_s4) : DEN_W'(den_s4);
			nmag1_s5 <= num1_s4[NUM_W-1] ? NUM_W'(-num1_s4) : NUM_W'(num1_s4);
			nmag2_s5 <= num2_s4[NUM_W-1] ? NUM_W'(-num2_s4) : NUM_W'(num2_s4);
			neg1_s5 <= num1_s4[NUM_W-1] ^ den_s4[DEN_W-1];
			neg2_s5 <= num2_s4[NUM_W-1] ^ den_s4[DEN_W-1];
			trk_s5.x1 <= x1_s4;
			trk_s5.y1 <= y1_s4;
			trk_s5.st <= st_s4;
			trk_s5.sp <= sp_s4;
			trk_s5.cp <= cp_s4;
			trk_s5.degen <= (den_s4 == '0);

			// carry track data past the divider
			trk_d[0] <= trk_s5;
			for (int k = 1; k < DIV_STEPS; k++) trk_d[k] <= trk_d[k-1];
		end
	end

	tpp_divider u_div_first (
		.clk(clk), .en(en), .num_mag(nmag1_s5), .den_mag(dmag_s5), .neg(neg1_s5),
		.quo(quo1), .ovf(ovf1), .quo_neg(qneg1)
	);

	tpp_divider u_div_second (
		.clk(clk), .en(en), .num_mag(nmag2_s5), .den_mag(dmag_s5), .neg(neg2_s5),
		.quo(quo2), .ovf(ovf2), .quo_neg(qneg2)
	);

	tpp_plane u_plane_first (
		.clk(clk), .en(en), .quo(quo1), .ovf(ovf1), .quo_neg(qneg1),
		.trk(trk_d[DIV_STEPS-1]), .off('0), .lift('0), .drop('0),
		.hbc(hbc_q), .hl(half_length_q), .sc(sec_tilt_q),
		.hit(hit1), .lx(lx1), .ly(ly1), .degen(degen1)
	);

	tpp_plane u_plane_second (
		.clk(clk), .en(en), .quo(quo2), .ovf(ovf2), .quo_neg(qneg2),
		.trk(trk_d[DIV_STEPS-1]), .off(off_q), .lift(hbc_q), .drop(half_breadth_q),
		.hbc(hbc_q), .hl(half_length_q), .sc(sec_tilt_q),
		.hit(hit2), .lx(lx2), .ly(ly2), .degen(degen2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (res_take) out_v_q <= vld_s[NS];
	end

	always_ff @(posedge clk) begin
		if (res_take && vld_s[NS]) begin
			hit1_q <= hit1;
			hit2_q <= hit2;
			degen_q <= degen1 & degen2;
			lx1_q <= lx1;
			ly1_q <= ly1;
			lx2_q <= lx2;
			ly2_q <= ly2;
		end
	end

	assign result.valid = out_v_q;
	assign result.hit_first = hit1_q;
	assign result.hit_second = hit2_q;
	assign result.both_hit = hit1_q & hit2_q;
	assign result.first_x = lx1_q;
	assign result.first_y = ly1_q;
	assign result.second_x = lx2_q;
	assign result.second_y = ly2_q;
	assign result.degenerate = degen_q;

	a_degen_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> !result.hit_first && !result.hit_second)
		else $error("degenerate result carries a hit");

	a_miss_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit_first |-> result.first_x == 0 && result.first_y == 0)
		else $error("missed first plane with nonzero coordinates");

	a_miss_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit_second |-> result.second_x == 0 && result.second_y == 0)
		else $error("missed second plane with nonzero coordinates");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!track.ready |-> vld_s[NS] && out_v_q && !result.ready)
		else $error("input held off with room in the pipeline");

	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_s == $past(vld_s))
		else $error("pipeline moved while stalled");

endmodule

// ----- rtl/core/tpp_sine.sv -----
// ----------------------------------------------------------------------------
// tpp_sine
// Quarter wave sine ROM with two read ports: sine and cosine of one angle.
// ----------------------------------------------------------------------------
module tpp_sine #(
	parameter int Depth = tpp_pkg::SINE_DEPTH
) (
	input  logic                clk,
	input  logic                en,
	input  logic [15:0]         ang,
	output logic signed [17:0]  sin_val,
	output logic signed [17:0]  cos_val
);
	import tpp_pkg::*;

	localparam int IW = $clog2(Depth + 1);

	typedef logic [SINE_W-1:0] rom_t [0:Depth];

	// Shift and subtract quotient, used only while building the table
	function automatic longint unsigned const_quo(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [SINE_W-1:0] sine_entry(input int i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint          sum;
		longint          v;
		x = const_quo(64'(longint'(i) * HALF_PI_Q30), 64'(Depth));
		x2 = (x * x) >> 30;
		t = x;
		sum = longint'(x);
		for (int k = 1; k <= 12; k++) begin
			t = const_quo((t * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
			if ((k & 1) != 0) sum = sum - longint'(t);
			else sum = sum + longint'(t);
		end
		if (sum < 0) sum = 0;
		v = (sum + (longint'(1) << (29 - FRAC))) >> (30 - FRAC);
		if (v > (longint'(1) << FRAC)) v = longint'(1) << FRAC;
		return SINE_W'(v);
	endfunction

	function automatic rom_t build_rom();
		rom_t tab;
		for (int i = 0; i <= Depth; i++) tab[i] = sine_entry(i);
		return tab;
	endfunction

	localparam rom_t ROM = build_rom();

	// Fold the angle into the first quadrant and round to the nearest entry
	function automatic logic [IW-1:0] rom_index(input logic [15:0] a);
		logic [14:0] pos;
		logic [31:0] full;
		pos = a[14] ? 15'(16384 - int'(a[13:0])) : {1'b0, a[13:0]};
		full = (32'(pos) * 32'(Depth) + 32'd8192) >> 14;
		return (full > 32'(Depth)) ? IW'(Depth) : full[IW-1:0];
	endfunction

	logic [15:0]       cos_ang;
	logic [IW-1:0]     sin_idx;
	logic [IW-1:0]     cos_idx;
	logic [SINE_W-1:0] sin_mag_s1;
	logic [SINE_W-1:0] cos_mag_s1;
	logic              sin_neg_s1;
	logic              cos_neg_s1;

	assign cos_ang = ang + 16'd16384;
	assign sin_idx = rom_index(ang);
	assign cos_idx = rom_index(cos_ang);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s1 <= ROM[sin_idx];
			cos_mag_s1 <= ROM[cos_idx];
			sin_neg_s1 <= ang[15];
			cos_neg_s1 <= cos_ang[15];
		end
	end

	assign sin_val = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
	assign cos_val = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});

endmodule

// ----- rtl/core/tpp_divider.sv -----
// ----------------------------------------------------------------------------
// tpp_divider
// Pipelined restoring divider: one quotient bit per stage, magnitude form.
// ----------------------------------------------------------------------------
module tpp_divider (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tpp_pkg::NUM_W-1:0]   num_mag,
	input  logic [tpp_pkg::DEN_W-1:0]   den_mag,
	input  logic                        neg,
	output logic [tpp_pkg::QUO_W-1:0]   quo,
	output logic                        ovf,
	output logic                        quo_neg
);
	import tpp_pkg::*;

	localparam int RW = NUM_W + FRAC;
	localparam int CW = DEN_W + QUO_W;

	logic [RW-1:0]    rem_s [0:DIV_STEPS-1];
	logic [DEN_W-1:0] den_s [0:DIV_STEPS-1];
	logic [QUO_W-1:0] quo_s [0:DIV_STEPS-1];
	logic             ovf_s [0:DIV_STEPS-1];
	logic             neg_s [0:DIV_STEPS-1];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int B = QUO_W - 1 - j;
		logic [RW-1:0]    rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic             ovf_in;
		logic             neg_in;
		logic [CW-1:0]    trial;
		logic             take;

		if (j == 0) begin : g_first
			assign rem_in = {num_mag, {FRAC{1'b0}}};
			assign den_in = den_mag;
			assign quo_in = '0;
			// quotient would not fit the quotient bits
			assign ovf_in = CW'(num_mag) >= (CW'(den_mag) << FRAC);
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
			assign ovf_in = ovf_s[j-1];
			assign neg_in = neg_s[j-1];
		end

		assign trial = CW'(den_in) << B;
		assign take = CW'(rem_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? RW'(CW'(rem_in) - trial) : rem_in;
				quo_s[j] <= quo_in | (take ? (QUO_W'(1) << B) : '0);
				den_s[j] <= den_in;
				ovf_s[j] <= ovf_in;
				neg_s[j] <= neg_in;
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];
	assign ovf = ovf_s[DIV_STEPS-1];
	assign quo_neg = neg_s[DIV_STEPS-1];

endmodule

// ----- rtl/core/tpp_plane.sv -----
// ----------------------------------------------------------------------------
// tpp_plane
// Path length to hit point, rectangle test and local coordinates of one plane.
// ----------------------------------------------------------------------------
module tpp_plane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tpp_pkg::QUO_W-1:0]   quo,
	input  logic                        ovf,
	input  logic                        quo_neg,
	input  tpp_pkg::trk_t               trk,
	input  logic signed [19:0]          off,
	input  logic [15:0]                 lift,
	input  logic [14:0]                 drop,
	input  logic [15:0]                 hbc,
	input  logic [14:0]                 hl,
	input  logic [18:0]                 sc,
	output logic                        hit,
	output logic signed [15:0]          lx,
	output logic signed [15:0]          ly,
	output logic                        degen
);
	import tpp_pkg::*;

	localparam logic [QUO_W-1:0] R_MAX = {1'b0, {(QUO_W-1){1'b1}}};
	localparam logic [QUO_W-1:0] R_MIN = {1'b1, {(QUO_W-1){1'b0}}};

	logic [QUO_W-1:0]    r_w;
	logic signed [31:0]  r_s1;
	trk_t                trk_s1;
	logic signed [33:0]  s_s2;
	trk_t                trk_s2;
	logic signed [51:0]  px_s3;
	logic signed [51:0]  py_s3;
	trk_t                trk_s3;
	logic signed [36:0]  x_s4;
	logic signed [37:0]  y_s4;
	logic                degen_s4;
	logic signed [36:0]  hl_x;
	logic signed [37:0]  hbc_y;
	logic signed [18:0]  ym;
	logic                in_w;
	logic                hit_s5;
	logic signed [15:0]  lx_s5;
	logic signed [38:0]  prod_s5;
	logic                degen_s5;
	logic signed [23:0]  yv;
	logic signed [15:0]  ysat;
	logic                hit_s6;
	logic signed [15:0]  lx_s6;
	logic signed [15:0]  ly_s6;
	logic                degen_s6;

	// Saturate the path length to the signed 32 bit range
	always_comb begin
		if (!quo_neg) r_w = (ovf || quo[QUO_W-1]) ? R_MAX : quo;
		else r_w = (ovf || quo > R_MIN) ? R_MIN : -quo;
	end

	assign hl_x = 37'(hl);
	assign hbc_y = 38'(hbc);
	assign in_w = (x_s4 <= hl_x) && (x_s4 >= -hl_x) && (y_s4 <= hbc_y) && (y_s4 >= -hbc_y);
	// inside the rectangle y fits 18 bits
	assign ym = 19'($signed(y_s4[17:0])) + $signed(19'(lift));
	assign yv = 24'(prod_s5 >>> FRAC) - $signed(24'(drop));

	always_comb begin
		if (yv > 24'sd32767) ysat = 16'sh7FFF;
		else if (yv < -24'sd32768) ysat = 16'sh8000;
		else ysat = yv[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_w;
			trk_s1 <= trk;
			s_s2 <= 34'((50'(r_s1) * 50'($signed(trk_s1.st))) >>> FRAC);
			trk_s2 <= trk_s1;
			px_s3 <= 52'(s_s2) * 52'($signed(trk_s2.cp));
			py_s3 <= 52'(s_s2) * 52'($signed(trk_s2.sp));
			trk_s3 <= trk_s2;
			x_s4 <= 37'($signed(trk_s3.x1)) + 37'(px_s3 >>> FRAC);
			y_s4 <= 38'($signed(trk_s3.y1)) + 38'(py_s3 >>> FRAC) - 38'(off);
			degen_s4 <= trk_s3.degen;
			hit_s5 <= in_w && !degen_s4;
			lx_s5 <= x_s4[15:0];
			prod_s5 <= 39'(ym) * 39'($signed({1'b0, sc}));
			degen_s5 <= degen_s4;
			hit_s6 <= hit_s5;
			lx_s6 <= hit_s5 ? lx_s5 : '0;
			ly_s6 <= hit_s5 ? ysat : '0;
			degen_s6 <= degen_s5;
		end
	end

	assign hit = hit_s6;
	assign lx = lx_s6;
	assign ly = ly_s6;
	assign degen = degen_s6;

endmodule
